@@ design/mmrpf_pkg.sv @@
// Package for the min/max range pruning filter: beat payload types, state and
// predicate structs, error and register codes, and the range match function.
// No dependencies.
`default_nettype none
package mmrpf_pkg;

	localparam int TIME_W      = 64;
	localparam int ROWS_W      = 32;
	localparam int ACC_W       = 64;
	localparam int CNT_W       = 17;
	localparam int IDX_OUT_W   = 16;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int GMAX_W      = 33;

	localparam logic [GMAX_W-1:0] GRANULE_CAP_DEF     = 33'd65536;
	localparam int                ROW_COUNT_BITS_DEF  = 32;
	localparam logic [CNT_W-1:0]  GRANULE_LIMIT_RESET = 17'd65536;

	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_VALUE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_MODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_VALUE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PART_MIN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PART_MAX      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GRANULE_LIMIT = 3'd6;

	localparam logic [MODE_W-1:0] MODE_EXCLUSIVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INCLUSIVE = 2'd2;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_PART_REV = 3'd1,
		ERR_GRAN_REV = 3'd2,
		ERR_ROW_OVF  = 3'd3,
		ERR_LIMIT    = 3'd4
	} err_t;

	typedef struct packed {
		logic signed [TIME_W-1:0] granule_min;
		logic signed [TIME_W-1:0] granule_max;
		logic [ROWS_W-1:0]        granule_rows;
		logic                     last_granule;
	} in_item_t;

	typedef struct packed {
		logic                 selected;
		logic [IDX_OUT_W-1:0] granule_index;
		logic [2:0]           error_code;
		logic [ACC_W-1:0]     selected_row_total;
		logic [ACC_W-1:0]     skipped_row_total;
		logic [CNT_W-1:0]     skipped_granule_total;
		logic                 final_res;
	} out_item_t;

	typedef struct packed {
		logic                     lo_present;
		logic                     lo_incl;
		logic signed [TIME_W-1:0] lo_value;
		logic                     hi_present;
		logic                     hi_incl;
		logic signed [TIME_W-1:0] hi_value;
		logic                     empty;
	} bounds_t;

	typedef struct packed {
		bounds_t          bounds;
		logic             part_rev;
		logic             part_ok;
		logic [CNT_W-1:0] limit;
	} gate_t;

	typedef struct packed {
		logic [CNT_W-1:0] next_index;
		logic [ACC_W-1:0] sel_acc;
		logic [ACC_W-1:0] skip_acc;
		logic [CNT_W-1:0] skip_cnt;
		err_t             err;
	} state_t;

	// true if a non-reversed range [lo, hi] may meet the predicate
	function automatic logic may_match(bounds_t b, logic signed [TIME_W-1:0] lo,
			logic signed [TIME_W-1:0] hi);
		logic below;
		logic above;
		below = b.lo_present && ((hi < b.lo_value) || (hi == b.lo_value && !b.lo_incl));
		above = b.hi_present && ((b.hi_value < lo) || (lo == b.hi_value && !b.hi_incl));
		return !b.empty && !below && !above;
	endfunction

endpackage
`default_nettype wire

@@ design/mmrpf_stream_if.sv @@
// Valid/ready stream channel carrying one payload per beat.
// Payload type is a parameter; no other dependencies.
`default_nettype none
interface mmrpf_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/mmrpf_cfg.sv @@
// Configuration registers and the derived predicate and part gate.
// Depends on mmrpf_pkg.
`default_nettype none
module mmrpf_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [mmrpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mmrpf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output mmrpf_pkg::gate_t                     gate
);
	import mmrpf_pkg::*;

	logic [MODE_W-1:0]        lower_mode_q;
	logic signed [TIME_W-1:0] lower_value_q;
	logic [MODE_W-1:0]        upper_mode_q;
	logic signed [TIME_W-1:0] upper_value_q;
	logic signed [TIME_W-1:0] part_min_q;
	logic signed [TIME_W-1:0] part_max_q;
	logic [CNT_W-1:0]         granule_limit_q;

	bounds_t bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_mode_q    <= '0;
			lower_value_q   <= '0;
			upper_mode_q    <= '0;
			upper_value_q   <= '0;
			part_min_q      <= '0;
			part_max_q      <= '0;
			granule_limit_q <= GRANULE_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOWER_MODE:    lower_mode_q    <= cfg_wdata[MODE_W-1:0];
				CFG_LOWER_VALUE:   lower_value_q   <= cfg_wdata[TIME_W-1:0];
				CFG_UPPER_MODE:    upper_mode_q    <= cfg_wdata[MODE_W-1:0];
				CFG_UPPER_VALUE:   upper_value_q   <= cfg_wdata[TIME_W-1:0];
				CFG_PART_MIN:      part_min_q      <= cfg_wdata[TIME_W-1:0];
				CFG_PART_MAX:      part_max_q      <= cfg_wdata[TIME_W-1:0];
				CFG_GRANULE_LIMIT: granule_limit_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		bnd.lo_present = (lower_mode_q == MODE_EXCLUSIVE) || (lower_mode_q == MODE_INCLUSIVE);
		bnd.lo_incl    = (lower_mode_q == MODE_INCLUSIVE);
		bnd.lo_value   = lower_value_q;
		bnd.hi_present = (upper_mode_q == MODE_EXCLUSIVE) || (upper_mode_q == MODE_INCLUSIVE);
		bnd.hi_incl    = (upper_mode_q == MODE_INCLUSIVE);
		bnd.hi_value   = upper_value_q;
		if (lower_value_q != upper_value_q)
			bnd.empty = bnd.lo_present && bnd.hi_present && (upper_value_q < lower_value_q);
		else
			bnd.empty = bnd.lo_present && bnd.hi_present && !(bnd.lo_incl && bnd.hi_incl);
	end

	always_comb begin
		gate.bounds   = bnd;
		gate.part_rev = (part_max_q < part_min_q);
		gate.part_ok  = may_match(bnd, part_min_q, part_max_q);
		gate.limit    = granule_limit_q;
	end
endmodule
`default_nettype wire

@@ design/mmrpf_step.sv @@
// Per-granule evaluation: limit and reversal checks, range test, row
// accumulation with overflow check, sticky error and end-of-part clear.
// Depends on mmrpf_pkg.
`default_nettype none
module mmrpf_step #(
	parameter logic [mmrpf_pkg::GMAX_W-1:0] GRANULE_CAP    = mmrpf_pkg::GRANULE_CAP_DEF,
	parameter int                           ROW_COUNT_BITS = mmrpf_pkg::ROW_COUNT_BITS_DEF
) (
	input  mmrpf_pkg::in_item_t  item,
	input  mmrpf_pkg::state_t    st,
	input  mmrpf_pkg::gate_t     gate,
	output mmrpf_pkg::out_item_t res,
	output mmrpf_pkg::state_t    nst
);
	import mmrpf_pkg::*;

	localparam int RB = (ROW_COUNT_BITS < ROWS_W) ? ROW_COUNT_BITS : ROWS_W;

	logic [ACC_W-1:0] rows;
	logic [ACC_W-1:0] acc;
	logic [ACC_W:0]   sum;
	logic             limit_hit;
	logic             sel;
	err_t             e;
	state_t           upd;

	assign rows = ACC_W'(item.granule_rows[RB-1:0]);
	assign limit_hit = (st.next_index >= gate.limit) ||
		({{(GMAX_W-CNT_W){1'b0}}, st.next_index} >= GRANULE_CAP);

	always_comb begin
		upd = st;
		sel = 1'b0;
		e   = ERR_NONE;
		acc = '0;
		sum = '0;
		if (st.err == ERR_NONE) begin
			if (limit_hit)
				e = ERR_LIMIT;
			else if (gate.part_rev)
				e = ERR_PART_REV;
			else if (gate.part_ok && (item.granule_max < item.granule_min))
				e = ERR_GRAN_REV;
			else
				sel = gate.part_ok && may_match(gate.bounds, item.granule_min, item.granule_max);
			acc = sel ? st.sel_acc : st.skip_acc;
			sum = {1'b0, acc} + {1'b0, rows};
			if (e == ERR_NONE) begin
				if (sum[ACC_W]) begin
					e = ERR_ROW_OVF;
				end else if (sel) begin
					upd.sel_acc = sum[ACC_W-1:0];
				end else begin
					upd.skip_acc = sum[ACC_W-1:0];
					upd.skip_cnt = st.skip_cnt + CNT_W'(1);
				end
			end
			if (e != ERR_NONE) begin
				upd.err = e;
				sel     = 1'b0;
			end
		end
		if (st.next_index != {CNT_W{1'b1}})
			upd.next_index = st.next_index + CNT_W'(1);

		res.selected              = sel;
		res.granule_index         = st.next_index[IDX_OUT_W-1:0];
		res.error_code            = upd.err;
		res.selected_row_total    = upd.sel_acc;
		res.skipped_row_total     = upd.skip_acc;
		res.skipped_granule_total = upd.skip_cnt;
		res.final_res             = item.last_granule;

		if (item.last_granule)
			nst = '{next_index: '0, sel_acc: '0, skip_acc: '0, skip_cnt: '0, err: ERR_NONE};
		else
			nst = upd;
	end
endmodule
`default_nettype wire

@@ design/min_max_range_pruning_filter.sv @@
// Zone-map min/max pruning filter, top level.
// Depends on mmrpf_pkg, mmrpf_stream_if, mmrpf_cfg and mmrpf_step.
//
// Usage:
//   granules: sink channel, one granule descriptor per beat (min, max, rows, last).
//   results:  source channel, exactly one result beat per granule, in order.
//   cfg_we/cfg_index/cfg_wdata: register writes, taken on any edge with cfg_we
//   high; write only while no granule is in flight.
// Timing:
//   Input register, then one combinational evaluation into the result register.
//   A granule beat taken into the input register is evaluated into the result
//   register, which offers it as a result beat. Throughput is one granule per
//   cycle unless results stalls; the running totals update in the same cycle
//   as the test. When results stalls, the result register holds its beat and
//   the input register holds one more granule; granules.ready then drops until
//   results takes a beat.
// Reset:
//   arst_n clears both stages, the counters, totals and sticky error; registers
//   return to their reset values (granule_limit 65536, others 0).
//   All counters and the error also clear after the result of a last granule.
`default_nettype none
module min_max_range_pruning_filter #(
	parameter logic [mmrpf_pkg::GMAX_W-1:0] GRANULE_CAP    = mmrpf_pkg::GRANULE_CAP_DEF,
	parameter int                           ROW_COUNT_BITS = mmrpf_pkg::ROW_COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	mmrpf_stream_if.sink                          granules,
	mmrpf_stream_if.source                        results,
	input  wire logic                             cfg_we,
	input  wire logic [mmrpf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mmrpf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mmrpf_pkg::*;

	gate_t     gate;
	in_item_t  item_s1;
	logic      v_s1;
	out_item_t res_s2;
	logic      v_s2;
	state_t    st_q;
	state_t    nst;
	out_item_t res;
	logic      s2_load;

	mmrpf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.gate      (gate)
	);

	mmrpf_step #(
		.GRANULE_CAP    (GRANULE_CAP),
		.ROW_COUNT_BITS (ROW_COUNT_BITS)
	) u_step (
		.item (item_s1),
		.st   (st_q),
		.gate (gate),
		.res  (res),
		.nst  (nst)
	);

	assign s2_load         = v_s1 && (!v_s2 || results.ready);
	assign granules.ready  = !v_s1 || s2_load;
	assign results.valid   = v_s2;
	assign results.payload = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (granules.ready) begin
			v_s1 <= granules.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (granules.ready && granules.valid)
			item_s1 <= granules.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_load) begin
			v_s2 <= 1'b1;
		end else if (results.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load)
			res_s2 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{next_index: '0, sel_acc: '0, skip_acc: '0, skip_cnt: '0, err: ERR_NONE};
		end else if (s2_load) begin
			st_q <= nst;
		end
	end

`ifndef ASSERT_OFF
	// input backs up only when both stages are full and the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!granules.ready |-> (v_s1 && v_s2 && !results.ready))
		else $error("granules.ready low without a full stalled pipeline");

	// end of part clears the counters
	assert property (@(posedge clk) disable iff (!arst_n)
		(s2_load && item_s1.last_granule) |=>
			(st_q.next_index == '0 && st_q.err == ERR_NONE && st_q.skip_cnt == '0))
		else $error("state not cleared after last granule");

	// sticky error holds within a part
	assert property (@(posedge clk) disable iff (!arst_n)
		(s2_load && st_q.err != ERR_NONE && !item_s1.last_granule) |=>
			(st_q.err == $past(st_q.err)))
		else $error("sticky error changed within a part");

	// a selected granule never carries an error
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !(results.payload.selected && results.payload.error_code != ERR_NONE))
		else $error("selected beat carries an error code");
`endif
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for min_max_range_pruning_filter: granule beats in, one result beat per granule.
// Depends on mmrpf_pkg and mmrpf_stream_if; a scoreboard class tracks the
// expected results, tasks drive the granule and register ports, and a process drives results.ready.
`timescale 1ns / 100ps
module tb;
	import mmrpf_pkg::*;

	localparam logic [MODE_W-1:0] MODE_ABSENT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
	localparam logic signed [TIME_W-1:0] T_MIN = 64'sh8000000000000000;
	localparam logic signed [TIME_W-1:0] T_MAX = 64'sh7FFFFFFFFFFFFFFF;
	localparam int HOLD_CYCLES = 150;
	localparam int RANDOM_GRANULES = 1250;

	class prune_tracker;
		logic [MODE_W-1:0]        lo_mode, hi_mode;
		logic signed [TIME_W-1:0] lo_val, hi_val, part_min, part_max;
		logic [CNT_W-1:0]         limit;
		logic [CNT_W-1:0]         ordinal_next;
		logic [ACC_W-1:0]         sel_rows, skip_rows;
		logic [CNT_W-1:0]         skip_cnt;
		err_t                     err;
		out_item_t                pending_results[$];
		int unsigned              errors;

		function new();
			lo_mode = MODE_ABSENT;
			hi_mode = MODE_ABSENT;
			lo_val = '0;
			hi_val = '0;
			part_min = '0;
			part_max = '0;
			limit = GRANULE_LIMIT_RESET;
			errors = 0;
			clear_part();
		endfunction

		function void clear_part();
			ordinal_next = '0;
			sel_rows = '0;
			skip_rows = '0;
			skip_cnt = '0;
			err = ERR_NONE;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_LOWER_MODE:    lo_mode = data[MODE_W-1:0];
				CFG_LOWER_VALUE:   lo_val = data;
				CFG_UPPER_MODE:    hi_mode = data[MODE_W-1:0];
				CFG_UPPER_VALUE:   hi_val = data;
				CFG_PART_MIN:      part_min = data;
				CFG_PART_MAX:      part_max = data;
				CFG_GRANULE_LIMIT: limit = data[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function bit bound_on(logic [MODE_W-1:0] m);
			return m == MODE_EXCLUSIVE || m == MODE_INCLUSIVE;
		endfunction

		function bit nothing_admitted();
			if (!bound_on(lo_mode) || !bound_on(hi_mode))
				return 1'b0;
			if (lo_val != hi_val)
				return hi_val < lo_val;
			return lo_mode != MODE_INCLUSIVE || hi_mode != MODE_INCLUSIVE;
		endfunction

		function bit overlaps(logic signed [TIME_W-1:0] lo, logic signed [TIME_W-1:0] hi);
			if (nothing_admitted())
				return 1'b0;
			if (bound_on(lo_mode) && (hi < lo_val || (hi == lo_val && lo_mode != MODE_INCLUSIVE)))
				return 1'b0;
			if (bound_on(hi_mode) && (hi_val < lo || (lo == hi_val && hi_mode != MODE_INCLUSIVE)))
				return 1'b0;
			return 1'b1;
		endfunction

		function void predict_granule(in_item_t g);
			logic signed [TIME_W-1:0] gmin, gmax;
			logic [GMAX_W-1:0]        lim;
			logic [ACC_W-1:0]         rows;
			logic [ACC_W:0]           sum;
			err_t                     hit;
			bit                       sel, gate;
			out_item_t                e;
			gmin = g.granule_min;
			gmax = g.granule_max;
			rows = ACC_W'(g.granule_rows);
			lim = GMAX_W'(limit);
			if (lim > GRANULE_CAP_DEF)
				lim = GRANULE_CAP_DEF;
			sel = 1'b0;
			if (err == ERR_NONE) begin
				hit = ERR_NONE;
				gate = 1'b0;
				if (GMAX_W'(ordinal_next) >= lim) begin
					hit = ERR_LIMIT;
				end else if (part_max < part_min) begin
					hit = ERR_PART_REV;
				end else begin
					gate = overlaps(part_min, part_max);
					if (gate && gmax < gmin)
						hit = ERR_GRAN_REV;
					else
						sel = gate && overlaps(gmin, gmax);
				end
				if (hit == ERR_NONE) begin
					sum = sel ? {1'b0, sel_rows} + {1'b0, rows} : {1'b0, skip_rows} + {1'b0, rows};
					if (sum[ACC_W]) begin
						hit = ERR_ROW_OVF;
					end else if (sel) begin
						sel_rows = sum[ACC_W-1:0];
					end else begin
						skip_rows = sum[ACC_W-1:0];
						skip_cnt = skip_cnt + 1'b1;
					end
				end
				if (hit != ERR_NONE) begin
					err = hit;
					sel = 1'b0;
				end
			end
			e.selected = sel;
			e.granule_index = ordinal_next[IDX_OUT_W-1:0];
			e.error_code = err;
			e.selected_row_total = sel_rows;
			e.skipped_row_total = skip_rows;
			e.skipped_granule_total = skip_cnt;
			e.final_res = g.last_granule;
			if (ordinal_next != '1)
				ordinal_next = ordinal_next + 1'b1;
			pending_results.insert(pending_results.size(), e);
			if (g.last_granule)
				clear_part();
		endfunction

		task report(string field, logic [63:0] got, logic [63:0] want, int unsigned idx);
			$display("error at %0t: granule %0d %s got %0h expected %0h", $realtime, idx,
				field, got, want);
			errors++;
		endtask

		task compare_result(out_item_t r);
			out_item_t w;
			if (pending_results.size() == 0) begin
				report("result with none pending", r.granule_index, 0, r.granule_index);
				return;
			end
			w = pending_results.pop_front();
			if (r.selected !== w.selected)
				report("selected", r.selected, w.selected, w.granule_index);
			if (r.granule_index !== w.granule_index)
				report("granule_index", r.granule_index, w.granule_index, w.granule_index);
			if (r.error_code !== w.error_code)
				report("error_code", r.error_code, w.error_code, w.granule_index);
			if (r.selected_row_total !== w.selected_row_total)
				report("selected_row_total", r.selected_row_total, w.selected_row_total,
					w.granule_index);
			if (r.skipped_row_total !== w.skipped_row_total)
				report("skipped_row_total", r.skipped_row_total, w.skipped_row_total,
					w.granule_index);
			if (r.skipped_granule_total !== w.skipped_granule_total)
				report("skipped_granule_total", r.skipped_granule_total,
					w.skipped_granule_total, w.granule_index);
			if (r.final_res !== w.final_res)
				report("final_res", r.final_res, w.final_res, w.granule_index);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mmrpf_stream_if #(.payload_t(in_item_t))  granules_if ();
	mmrpf_stream_if #(.payload_t(out_item_t)) results_if ();

	min_max_range_pruning_filter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.granules(granules_if),
		.results(results_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	prune_tracker tracker;
	bit no_gaps;
	bit hold_req;
	int n_random;
	int phase;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (results_if.valid && results_if.ready)
				tracker.compare_result(results_if.payload);
			if (granules_if.valid && granules_if.ready)
				tracker.predict_granule(granules_if.payload);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// result side: ready bursts and gaps, plus a long hold-off on request
	initial begin
		int burst, gap;
		results_if.ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				results_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			results_if.ready = 1'b1;
			burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
			repeat (burst) @(negedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				results_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic in_item_t granule(logic signed [TIME_W-1:0] gmin,
			logic signed [TIME_W-1:0] gmax, logic [ROWS_W-1:0] rows, logic last);
		in_item_t g;
		g.granule_min = gmin;
		g.granule_max = gmax;
		g.granule_rows = rows;
		g.last_granule = last;
		return g;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_granule(in_item_t g);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			granules_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		granules_if.valid = 1'b1;
		granules_if.payload = g;
		do
			@(posedge clk);
		while (!granules_if.ready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (tracker.pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic program_regs(logic [MODE_W-1:0] lm, logic signed [TIME_W-1:0] lv,
			logic [MODE_W-1:0] um, logic signed [TIME_W-1:0] uv,
			logic signed [TIME_W-1:0] pmin, logic signed [TIME_W-1:0] pmax,
			logic [CNT_W-1:0] lim);
		logic [CFG_IDX_W-1:0]  idx [7];
		logic [CFG_DATA_W-1:0] val [7];
		granules_if.valid = 1'b0;
		wait_idle();
		repeat (3) @(negedge clk);
		idx = '{CFG_LOWER_MODE, CFG_LOWER_VALUE, CFG_UPPER_MODE, CFG_UPPER_VALUE,
			CFG_PART_MIN, CFG_PART_MAX, CFG_GRANULE_LIMIT};
		val = '{64'(lm), lv, 64'(um), uv, pmin, pmax, 64'(lim)};
		foreach (idx[i]) begin
			cfg_we = 1'b1;
			cfg_index = idx[i];
			cfg_wdata = val[i];
			tracker.write_reg(idx[i], val[i]);
			@(negedge clk);
		end
		cfg_we = 1'b0;
	endtask

	function automatic logic signed [TIME_W-1:0] pick_bound();
		case ($urandom_range(0, 9))
			0: return T_MIN;
			1: return T_MAX;
			2, 3: return {$urandom, $urandom};
			default: return int'($urandom_range(0, 200)) - 100;
		endcase
	endfunction

	function automatic logic signed [TIME_W-1:0] pick_time();
		case ($urandom_range(0, 9))
			0: return {$urandom, $urandom};
			1: return $urandom_range(0, 1) ? T_MIN : T_MAX;
			2, 3, 4: return tracker.lo_val + (int'($urandom_range(0, 6)) - 3);
			5, 6, 7: return tracker.hi_val + (int'($urandom_range(0, 6)) - 3);
			default: return int'($urandom_range(0, 240)) - 120;
		endcase
	endfunction

	task automatic random_config();
		logic [MODE_W-1:0]        lm, um;
		logic signed [TIME_W-1:0] lv, uv, pa, pb, t;
		logic [CNT_W-1:0]         lim;
		int                       r;
		lm = MODE_W'($urandom_range(0, 3));
		um = MODE_W'($urandom_range(0, 3));
		lv = pick_bound();
		uv = ($urandom_range(0, 2) == 0) ? pick_bound() : lv + (int'($urandom_range(0, 40)) - 10);
		pa = pick_bound();
		pb = pick_bound();
		if (pb < pa) begin
			t = pa;
			pa = pb;
			pb = t;
		end
		r = $urandom_range(0, 11);
		if (r == 0) begin
			pa = T_MIN;
			pb = T_MAX;
		end else if (r == 1) begin
			t = pa;
			pa = pb;
			pb = t;
		end
		case ($urandom_range(0, 9))
			6: lim = '0;
			7: lim = CNT_W'($urandom_range(1, 20));
			8: lim = '1;
			9: lim = 17'd65535;
			default: lim = GRANULE_LIMIT_RESET;
		endcase
		program_regs(lm, lv, um, uv, pa, pb, lim);
	endtask

	task automatic random_granule(logic last);
		logic signed [TIME_W-1:0] a, b, t;
		logic [ROWS_W-1:0]        rows;
		a = pick_time();
		b = ($urandom_range(0, 7) == 0) ? a : pick_time();
		if ($urandom_range(0, 24) != 0 && b < a) begin
			t = a;
			a = b;
			b = t;
		end
		case ($urandom_range(0, 9))
			0: rows = '0;
			1: rows = '1;
			default: rows = $urandom;
		endcase
		send_granule(granule(a, b, rows, last));
	endtask

	initial begin
		int n_parts, len;
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		granules_if.valid = 1'b0;
		granules_if.payload = '0;
		hold_req = 1'b0;
		no_gaps = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: no bounds, part 0..0
		send_granule(granule(T_MIN, T_MAX, '1, 1'b0));
		send_granule(granule(0, 0, 0, 1'b0));
		send_granule(granule(5, -5, 7, 1'b0));
		send_granule(granule(0, 0, 1, 1'b1));
		// inclusive lower, exclusive upper
		program_regs(MODE_INCLUSIVE, 10, MODE_EXCLUSIVE, 20, -100, 100, GRANULE_LIMIT_RESET);
		send_granule(granule(0, 9, 3, 1'b0));
		send_granule(granule(0, 10, 4, 1'b0));
		send_granule(granule(20, 30, 5, 1'b0));
		send_granule(granule(19, T_MAX, 6, 1'b1));
		program_regs(MODE_EXCLUSIVE, 10, MODE_INCLUSIVE, 20, -100, 100, GRANULE_LIMIT_RESET);
		send_granule(granule(0, 10, 1, 1'b0));
		send_granule(granule(20, 25, 1, 1'b0));
		send_granule(granule(11, 11, 1, 1'b1));
		// empty predicate: equal bounds, one exclusive
		program_regs(MODE_INCLUSIVE, 5, MODE_EXCLUSIVE, 5, -100, 100, GRANULE_LIMIT_RESET);
		send_granule(granule(T_MIN, T_MAX, 9, 1'b0));
		send_granule(granule(5, 5, 1, 1'b1));
		program_regs(MODE_INCLUSIVE, 5, MODE_INCLUSIVE, 5, -100, 100, GRANULE_LIMIT_RESET);
		send_granule(granule(5, 5, 2, 1'b0));
		send_granule(granule(6, 9, 2, 1'b1));
		program_regs(MODE_INCLUSIVE, 30, MODE_INCLUSIVE, 20, -100, 100, GRANULE_LIMIT_RESET);
		send_granule(granule(0, 100, 1, 1'b1));
		// empty predicate with reversed part extrema still flags the part
		program_regs(MODE_INCLUSIVE, 30, MODE_INCLUSIVE, 20, 100, -100, GRANULE_LIMIT_RESET);
		send_granule(granule(0, 0, 1, 1'b0));
		send_granule(granule(0, 0, 1, 1'b1));
		// closed part gate: granule reversal not checked
		program_regs(MODE_INCLUSIVE, 1000, MODE_ABSENT, 0, -100, 100, GRANULE_LIMIT_RESET);
		send_granule(granule(2000, 3000, 1, 1'b0));
		send_granule(granule(5, -5, 1, 1'b1));
		program_regs(MODE_SPARE, 50, MODE_SPARE, -50, 0, 0, GRANULE_LIMIT_RESET);
		send_granule(granule(T_MIN, T_MIN, 1, 1'b1));
		// granule limit
		program_regs(MODE_ABSENT, 0, MODE_ABSENT, 0, T_MIN, T_MAX, CNT_W'(2));
		send_granule(granule(1, 2, 1, 1'b0));
		send_granule(granule(1, 2, 1, 1'b0));
		send_granule(granule(1, 2, 1, 1'b0));
		send_granule(granule(1, 2, 1, 1'b1));
		program_regs(MODE_ABSENT, 0, MODE_ABSENT, 0, T_MIN, T_MAX, CNT_W'(0));
		send_granule(granule(0, 0, 1, 1'b1));

		n_random = 0;
		phase = 0;
		while (n_random < RANDOM_GRANULES) begin
			random_config();
			no_gaps = ($urandom_range(0, 5) == 0);
			n_parts = $urandom_range(1, 3);
			for (int p = 0; p < n_parts; p++) begin
				len = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
				if (p == 0 && phase % 20 == 2)
					hold_req = 1'b1;
				for (int j = 0; j < len; j++) begin
					if (p == 0 && phase % 20 == 7 && j == len / 2) begin
						granules_if.valid = 1'b0;
						wait_idle();
					end
					random_granule(j == len - 1);
					n_random++;
				end
			end
			phase++;
		end

		granules_if.valid = 1'b0;
		wait_idle();
		repeat (10) @(negedge clk);
		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

@@ filelist.f @@
design/mmrpf_pkg.sv
design/mmrpf_stream_if.sv
design/mmrpf_cfg.sv
design/mmrpf_step.sv
design/min_max_range_pruning_filter.sv
tb/sv/tb.sv
